[rtl/vtfa_pkg.sv]
// ----------------------------------------------------------------------------
// vtfa_pkg: shared types and constants of the vertex transform fan assembler
// Holds the vertex record, the corner record passed from the front to the
// back part, and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package vtfa_pkg;

  localparam int unsigned NumCfg   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRow0A = 3'd0,
    CfgRow0B = 3'd1,
    CfgRow1A = 3'd2,
    CfgRow1B = 3'd3,
    CfgRow2A = 3'd4,
    CfgRow2B = 3'd5,
    CfgRow3A = 3'd6,
    CfgRow3B = 3'd7
  } cfg_idx_e;

  localparam logic [CfgDataW-1:0] CfgReset [NumCfg] = '{
    64'h0000_0001_0000_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // One corner as it leaves the front part.
  typedef struct packed {
    logic               face_start;
    logic signed [31:0] norm_z;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_x;
    logic signed [31:0] tex_v;
    logic signed [31:0] tex_u;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } corner_t;

  // One finished vertex.
  typedef struct packed {
    logic               w_zero;
    logic signed [31:0] nz;
    logic signed [31:0] ny;
    logic signed [31:0] nx;
    logic signed [31:0] v;
    logic signed [31:0] u;
    logic signed [31:0] w;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vertex_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

[rtl/vertex_transform_fan_assembler.sv]
// ----------------------------------------------------------------------------
// vertex_transform_fan_assembler: matrix transform, divide by w, fan assembly
// Top level: configuration registers, input queue and transform back end.
// ----------------------------------------------------------------------------
// Usage:
//   Corners arrive on the s_axis channel (tdata = position, texture, normal;
//   tuser = face_start). Each corner is multiplied by the 4x4 matrix held in
//   eight 64-bit registers written through cfg_we_i/cfg_idx_i/cfg_data_i, then
//   x, y and z are divided by w. From the third corner of a face on, each
//   corner yields three vertex transactions on m_axis, the third with tlast.
//   A two-entry queue takes corners while the back end is busy.
//   Per corner the back end takes the corner, forms the products on the shared
//   multiplier and then the row sums, runs three divides on the serial divider
//   (each skipped when w is zero), and emits three vertices when a triangle is
//   due. It takes no new corner until it has finished with the last one.
//   Reset loads the matrix in vtfa_pkg::CfgReset and starts a new face. When m_axis stalls
//   the back end holds its vertex and the queue then fills and drops tready.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_transform_fan_assembler #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire [2:0]    cfg_idx_i,
  input  wire [63:0]   cfg_data_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
  input  wire [255:0]  s_axis_tdata,
  // tuser: face_start
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata: out_x, out_y, out_z, out_w, out_u, out_v, out_nx, out_ny, out_nz
  output logic [287:0] m_axis_tdata,
  // tuser: w_zero
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  logic [vtfa_pkg::CfgDataW-1:0] cfg_q [vtfa_pkg::NumCfg];
  vtfa_pkg::corner_t cin, cq;
  vtfa_pkg::vertex_t vtx;
  logic q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vtfa_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign cin = '{face_start: s_axis_tuser,
                 norm_z: s_axis_tdata[255:224], norm_y: s_axis_tdata[223:192],
                 norm_x: s_axis_tdata[191:160], tex_v: s_axis_tdata[159:128],
                 tex_u: s_axis_tdata[127:96], pos_z: s_axis_tdata[95:64],
                 pos_y: s_axis_tdata[63:32], pos_x: s_axis_tdata[31:0]};

  vtfa_fifo u_fifo (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(cin), .out_valid_o(q_valid), .out_ready_i(q_ready),
    .out_data_o(cq)
  );

  vtfa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i(q_valid), .in_ready_o(q_ready),
    .in_data_i(cq), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_vtx_o(vtx), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {vtx.nz, vtx.ny, vtx.nx, vtx.v, vtx.u,
                         vtx.w, vtx.z, vtx.y, vtx.x};
  assign m_axis_tuser = vtx.w_zero;

endmodule
`default_nettype wire

[rtl/vtfa_fifo.sv]
// ----------------------------------------------------------------------------
// vtfa_fifo: corner queue between front and back
// Small two-entry queue that lets the input side and the transform side stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none
module vtfa_fifo (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire vtfa_pkg::corner_t     in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output vtfa_pkg::corner_t          out_data_o
);

  vtfa_pkg::corner_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rptr_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wptr_q == rptr_q)
    else $error("queue pointers inconsistent");

endmodule
`default_nettype wire

[rtl/vtfa_divider.sv]
// ----------------------------------------------------------------------------
// vtfa_divider: signed restoring divider
// Divides a 66-bit signed numerator by a 32-bit signed divisor one quotient
// bit per cycle, truncating toward zero, and saturates to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module vtfa_divider (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  wire signed [65:0]  num_i,
  input  wire signed [31:0]  den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int unsigned NW = 66;

  logic [NW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0]   den_q;
  logic          neg_q, busy_q;
  logic [6:0]    cnt_q;
  logic [NW:0]   trial;
  logic [NW-1:0] num_abs;
  logic [NW:0]   q_signed;

  assign num_abs = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
  assign trial   = {rem_q, quo_q[NW-1]} - {{(NW-31){1'b0}}, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = {quo_q[NW-2:0], 1'b0};
    if (!trial[NW]) begin
      rem_d    = trial[NW-1:0];
      quo_d[0] = 1'b1;
    end else begin
      rem_d = {rem_q[NW-2:0], quo_q[NW-1]};
    end
  end

  assign q_signed = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_abs;
      den_q <= den_i[31] ? (~den_i + 1'b1) : den_i;
      neg_q <= num_i[NW-1] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_comb begin
    if (!neg_q && quo_q > 66'h0_7FFF_FFFF) begin
      quo_o = 32'sh7FFF_FFFF;
    end else if (neg_q && quo_q > 66'h0_8000_0000) begin
      quo_o = 32'sh8000_0000;
    end else begin
      quo_o = q_signed[31:0];
    end
  end

endmodule
`default_nettype wire

[rtl/vtfa_back.sv]
// ----------------------------------------------------------------------------
// vtfa_back: transform, divide and fan emit
// Forms the four clip rows with one shared multiplier, divides x, y and z by
// w on a serial divider, and emits fan triangles from the stored corners.
// ----------------------------------------------------------------------------
`default_nettype none
module vtfa_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire [vtfa_pkg::CfgDataW-1:0]         cfg_i [vtfa_pkg::NumCfg],
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire vtfa_pkg::corner_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output vtfa_pkg::vertex_t                    out_vtx_o,
  output logic                                 out_last_o
);

  localparam int unsigned LoW = FRAC_BITS + 2;

  typedef enum logic [2:0] {
    StIdle, StMul, StFlush, StSum, StDiv, StWait, StEmit
  } state_e;

  state_e             state_q;
  vtfa_pkg::corner_t  cor_q;
  logic [1:0]         row_q, col_q, comp_q, seen_q, emit_q;
  logic signed [63:0] prod_q;
  logic               prod_v_q;
  logic [1:0]         pcol_q;
  logic signed [65:0] hi_q;
  logic [LoW-1:0]     lo_q;
  logic signed [31:0] clip_q [4];
  vtfa_pkg::vertex_t  cur_q, anchor_q, prev_q;
  vtfa_pkg::vertex_t  fin_vtx;
  logic               div_start, div_done;
  logic signed [31:0] div_quo;
  logic signed [31:0] coef, opnd;
  logic [vtfa_pkg::CfgDataW-1:0] creg;
  logic signed [63:0] fl;
  logic [FRAC_BITS-1:0] lm;
  logic signed [65:0] rowsum;
  logic signed [65:0] num;
  logic signed [31:0] zq;
  logic signed [31:0] zres;

  assign creg = cfg_i[{row_q, col_q[1]}];
  assign coef = col_q[0] ? creg[63:32] : creg[31:0];
  always_comb begin
    unique case (col_q)
      2'd0:    opnd = cor_q.pos_x;
      2'd1:    opnd = cor_q.pos_y;
      2'd2:    opnd = cor_q.pos_z;
      default: opnd = 32'sd1 <<< FRAC_BITS;
    endcase
  end

  assign fl = prod_q >>> FRAC_BITS;
  assign lm = prod_q[FRAC_BITS-1:0];
  assign rowsum = hi_q + 66'(lo_q >> FRAC_BITS);
  assign num = 66'(clip_q[comp_q]) <<< FRAC_BITS;
  assign div_start = (state_q == StDiv) && (clip_q[3] != 32'sd0);
  assign zq = (clip_q[comp_q] > 0) ? 32'sh7FFF_FFFF :
              (clip_q[comp_q] < 0) ? 32'sh8000_0000 : 32'sd0;
  assign zres = (clip_q[3] == 32'sd0) ? zq : div_quo;

  // The finished vertex once its z arrives.
  always_comb begin
    fin_vtx   = cur_q;
    fin_vtx.z = zres;
  end

  vtfa_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(clip_q[3]),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  always_comb begin
    unique case (emit_q)
      2'd0:    out_vtx_o = anchor_q;
      2'd1:    out_vtx_o = prev_q;
      default: out_vtx_o = cur_q;
    endcase
  end
  assign out_last_o = (emit_q == 2'd2);

  always_ff @(posedge clk_i) begin
    prod_q <= coef * opnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      seen_q   <= 2'd0;
      prod_v_q <= 1'b0;
      row_q <= '0; col_q <= '0; comp_q <= '0; emit_q <= '0;
      pcol_q <= '0;
    end else begin
      prod_v_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          cor_q   <= in_data_i;
          row_q   <= '0;
          col_q   <= '0;
          state_q <= StMul;
        end
        StMul: begin
          prod_v_q <= 1'b1;
          pcol_q   <= col_q;
          col_q    <= col_q + 2'd1;
          if (col_q == 2'd3) begin
            row_q <= row_q + 2'd1;
            if (row_q == 2'd3) state_q <= StFlush;
          end
        end
        // The last product of row 3 is still being added.
        StFlush: state_q <= StSum;
        StSum: begin
          comp_q  <= '0;
          state_q <= StDiv;
        end
        StDiv: state_q <= StWait;
        StWait: begin
          if (clip_q[3] == 32'sd0 || div_done) begin
            unique case (comp_q)
              2'd0:    cur_q.x <= zres;
              2'd1:    cur_q.y <= zres;
              default: cur_q.z <= zres;
            endcase
            if (comp_q == 2'd2) begin
              if (cor_q.face_start || seen_q == 2'd0) begin
                anchor_q <= fin_vtx;
                seen_q   <= 2'd1;
                state_q  <= StIdle;
              end else if (seen_q == 2'd1) begin
                prev_q  <= fin_vtx;
                seen_q  <= 2'd2;
                state_q <= StIdle;
              end else begin
                emit_q  <= 2'd0;
                state_q <= StEmit;
              end
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= StDiv;
            end
          end
        end
        StEmit: if (out_ready_i) begin
          emit_q <= emit_q + 2'd1;
          if (emit_q == 2'd2) begin
            prev_q  <= cur_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      // Accumulate the row product in a floor part and a fraction part.
      if (prod_v_q) begin
        if (pcol_q == 2'd0) begin
          hi_q <= 66'(fl);
          lo_q <= LoW'(lm);
        end else begin
          hi_q <= hi_q + 66'(fl);
          lo_q <= lo_q + LoW'(lm);
        end
      end
      // A row is complete once its last product has passed prod_q and been added into hi_q and lo_q.
      if (state_q == StMul && col_q == 2'd1 && (row_q != 2'd0)) begin
        clip_q[row_q - 2'd1] <= vtfa_pkg::sat32(rowsum);
      end
      if (state_q == StSum) begin
        clip_q[3] <= vtfa_pkg::sat32(rowsum);
        cur_q.w   <= vtfa_pkg::sat32(rowsum);
        cur_q.w_zero <= (vtfa_pkg::sat32(rowsum) == 32'sd0);
        cur_q.u  <= cor_q.tex_u;
        cur_q.v  <= cor_q.tex_v;
        cur_q.nx <= cor_q.norm_x;
        cur_q.ny <= cor_q.norm_y;
        cur_q.nz <= cor_q.norm_z;
      end
    end
  end

  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3) else $error("corner count out of range");
  a_emit_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> seen_q == 2'd2) else $error("emit before two corners");
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> emit_q != 2'd3) else $error("emit index out of range");

endmodule
`default_nettype wire
